// ----- hw/rtl/grc_pkg.sv -----
// Shared constants, codes, types and the floor-glyph function of the ray-cast renderer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package grc_pkg;

  // Map and screen geometry
  localparam int unsigned MAP_SIZE    = 32;
  localparam int unsigned MAP_AW      = $clog2(MAP_SIZE);
  localparam int unsigned MAP_CELLS   = MAP_SIZE * MAP_SIZE;
  localparam int unsigned MAP_IDX_W   = 2 * MAP_AW;
  localparam int unsigned SCREEN_ROWS = 40;
  localparam int unsigned SCREEN_COLS = 120;
  localparam int unsigned HALF_ROWS   = SCREEN_ROWS / 2;
  localparam int unsigned LH_MAX      = 2 * SCREEN_ROWS;

  // Field widths
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned POS_W      = 15;
  localparam int unsigned VEC_W      = 16;
  localparam int unsigned FRAC_POS   = 10;
  localparam int unsigned FRAC_VEC   = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Walk arithmetic widths
  localparam int unsigned RAY_W   = 18;  // signed ray component
  localparam int unsigned ABS_W   = 17;  // magnitude of a ray component
  localparam int unsigned DIST_W  = 18;  // boundary distance accumulator, Q10
  localparam int unsigned CELL_W  = MAP_AW + 2;  // signed cell index with overrun room
  localparam int unsigned MUL_W   = 19;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // Divider widths
  localparam int unsigned DVD_W = 25;
  localparam int unsigned DVS_W = 22;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Cell kinds
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_NEAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_MID    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_FAR    = 2'd3;

  // Glyph codes
  localparam logic [2:0] GLYPH_SPACE = 3'd0;
  localparam logic [2:0] GLYPH_HASH  = 3'd1;
  localparam logic [2:0] GLYPH_X     = 3'd2;
  localparam logic [2:0] GLYPH_PLUS  = 3'd3;
  localparam logic [2:0] GLYPH_COLON = 3'd4;
  localparam logic [2:0] GLYPH_DOT   = 3'd5;
  localparam logic [2:0] GLYPH_EXIT  = 3'd6;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  // Floor glyph below the wall span: depends on the screen row alone
  function automatic logic [2:0] floor_glyph(input logic [ROW_W-1:0] y);
    logic signed [9:0] k;
    logic [2:0]        g;
    k = $signed({3'b000, y, 1'b0}) - $signed(10'(SCREEN_ROWS));
    if (k == 10'sd0) begin
      g = GLYPH_SPACE;
    end else if (k < 10'sd0) begin
      g = GLYPH_PLUS;
    end else if ($signed(10'(SCREEN_ROWS)) < 2 * k) begin
      g = GLYPH_PLUS;
    end else if ($signed(10'(SCREEN_ROWS)) < 3 * k) begin
      g = GLYPH_DOT;
    end else begin
      g = GLYPH_SPACE;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/grc_in_if.sv -----
// Input channel of the ray-cast renderer: valid/ready plus the command payload.
// Depends on grc_pkg for field widths.
`default_nettype none

interface grc_in_if;
  import grc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [MAP_AW-1:0]       cell_row;
  logic [MAP_AW-1:0]       cell_col;
  logic [1:0]              cell_kind;
  logic [COL_W-1:0]        column;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic signed [VEC_W-1:0] dir_x;
  logic signed [VEC_W-1:0] dir_y;
  logic signed [VEC_W-1:0] plane_x;
  logic signed [VEC_W-1:0] plane_y;

  modport source (
    output valid, cmd, cell_row, cell_col, cell_kind, column,
           pos_x, pos_y, dir_x, dir_y, plane_x, plane_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, cell_row, cell_col, cell_kind, column,
           pos_x, pos_y, dir_x, dir_y, plane_x, plane_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/grc_out_if.sv -----
// Output channel of the ray-cast renderer: valid/ready plus one glyph per transaction.
// Depends on grc_pkg for field widths.
`default_nettype none

interface grc_out_if;
  import grc_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] row;
  logic [2:0]       glyph;
  logic             last;

  modport source (output valid, out_column, row, glyph, last, input ready);
  modport sink   (input valid, out_column, row, glyph, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/grc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ray-cast renderer.
// Depends on grc_pkg (widths, request and response types).
`default_nettype none

module grc_div import grc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      // shift the next dividend bit in, subtract where the divisor fits
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/grid_raycast_column_renderer.sv -----
// Grid ray-cast column renderer: map store, DDA walk on one shared multiplier, glyph output.
// Sequence: a cell write is stored as it is taken; a cast runs the setup, a walk step for each cell
// stepped, then the height division and shading, then 40 glyph rows.
// Throughput: one item at a time; the input is not ready while a cast is in progress.
// Reset: asynchronous, active low; afterwards the map is swept to empty, all 1024 cells,
// with the input held not ready. Config registers take their defaults at reset.
// Depends on grc_pkg, grc_in_if, grc_out_if and grc_div.
`default_nettype none

module grid_raycast_column_renderer import grc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  grc_in_if.sink                in_i,
  grc_out_if.source             out_o
);

  // Sequencer states
  localparam logic [4:0] ST_CLR  = 5'd0;   // sweep map to empty
  localparam logic [4:0] ST_IDLE = 5'd1;   // take a transaction
  localparam logic [4:0] ST_MULX = 5'd3;   // plane_x * cam
  localparam logic [4:0] ST_MULY = 5'd4;   // plane_y * cam, form x ray
  localparam logic [4:0] ST_INIT = 5'd5;   // form y ray
  localparam logic [4:0] ST_S1   = 5'd6;   // tx * ay
  localparam logic [4:0] ST_S2   = 5'd7;   // ty * ax, hold tx * ay
  localparam logic [4:0] ST_S3   = 5'd8;   // compare and step
  localparam logic [4:0] ST_RD   = 5'd9;   // bounds check, read map
  localparam logic [4:0] ST_CHK  = 5'd10;  // test the cell
  localparam logic [4:0] ST_LHM  = 5'd11;  // height_scale * den
  localparam logic [4:0] ST_LHD  = 5'd12;  // launch height division
  localparam logic [4:0] ST_LHW  = 5'd13;  // wait for height
  localparam logic [4:0] ST_SH0  = 5'd14;  // shade_near * den
  localparam logic [4:0] ST_SH1  = 5'd15;  // shade_mid * den
  localparam logic [4:0] ST_SH2  = 5'd16;  // shade_far * den
  localparam logic [4:0] ST_SH3  = 5'd17;  // last compare
  localparam logic [4:0] ST_EMIT = 5'd18;  // stream the rows

  localparam int unsigned CELL_STEP = 1 << FRAC_POS;

  logic [4:0] state_q, state_d;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] hs_q;
  logic [4:0] near_q, mid_q, far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q   <= 8'd64;
      near_q <= 5'd3;
      mid_q  <= 5'd5;
      far_q  <= 5'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEIGHT_SCALE: hs_q   <= cfg_data_i;
        REG_SHADE_NEAR:   near_q <= cfg_data_i[4:0];
        REG_SHADE_MID:    mid_q  <= cfg_data_i[4:0];
        REG_SHADE_FAR:    far_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Map store: written by cell transactions or the clearing sweep, read during the walk
  // ---------------------------------------------------------------------------
  logic [1:0]           map_q [MAP_CELLS];
  logic [1:0]           rd_q;
  logic [MAP_IDX_W-1:0] clr_q;
  logic                 in_acc;
  logic                 cell_we;
  logic [CELL_W-1:0]    mx_q, my_q;
  logic [MAP_IDX_W-1:0] rd_addr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cell_we    = in_acc && (in_i.cmd == CMD_WRITE);
  assign rd_addr    = {mx_q[MAP_AW-1:0], my_q[MAP_AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLR) begin
      map_q[clr_q] <= KIND_EMPTY;
    end else if (cell_we) begin
      map_q[{in_i.cell_row, in_i.cell_col}] <= in_i.cell_kind;
    end
    rd_q <= map_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == ST_CLR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: wall height from height_scale * den over 16 * num
  // ---------------------------------------------------------------------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [DIST_W-1:0] num_q;
  logic [ABS_W-1:0]  den_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [COL_W-1:0]  col_q;

  always_comb begin
    div_req.start    = (state_q == ST_LHD) && (num_q != '0);
    div_req.dividend = prod_q[DVD_W-1:0];
    div_req.divisor  = {num_q, 4'd0};
  end

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Camera offset floor(column * 2^15 / 120) - 2^14: 2^15 / 120 = 273 + 1/15, and
  // floor(column / 15) = (column * 137) >> 11 holds for every 7-bit column
  logic [14:0]      col_x137;
  logic [VEC_W-1:0] cam_base;

  assign col_x137 = 15'(in_i.column) * 15'd137;
  assign cam_base = VEC_W'(in_i.column) * VEC_W'(273) + VEC_W'(col_x137[14:11]);

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands picked by the sequencer, product registered
  // ---------------------------------------------------------------------------
  logic signed [VEC_W-1:0] plx_q, ply_q, dirx_q, diry_q, cam_q;
  logic [POS_W-1:0]        px_q, py_q;
  logic [ABS_W-1:0]        ax_q, ay_q;
  logic [DIST_W-1:0]       tx_q, ty_q;
  logic signed [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MULX: begin
        mul_a = MUL_W'(plx_q);
        mul_b = MUL_W'(cam_q);
      end
      ST_MULY: begin
        mul_a = MUL_W'(ply_q);
        mul_b = MUL_W'(cam_q);
      end
      ST_S1, ST_CHK: begin
        mul_a = $signed({1'b0, tx_q});
        mul_b = $signed({2'b00, ay_q});
      end
      ST_S2: begin
        mul_a = $signed({1'b0, ty_q});
        mul_b = $signed({2'b00, ax_q});
      end
      ST_LHM: begin
        mul_a = $signed({11'd0, hs_q});
        mul_b = $signed({2'b00, den_q});
      end
      ST_SH0: begin
        mul_a = $signed({14'd0, near_q});
        mul_b = $signed({2'b00, den_q});
      end
      ST_SH1: begin
        mul_a = $signed({14'd0, mid_q});
        mul_b = $signed({2'b00, den_q});
      end
      ST_SH2: begin
        mul_a = $signed({14'd0, far_q});
        mul_b = $signed({2'b00, den_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Ray components: dir + floor(plane * cam / 2^14); the arithmetic shift floors
  logic signed [RAY_W-1:0] ray;
  logic [ABS_W-1:0]        ray_abs;

  assign ray     = RAY_W'((state_q == ST_MULY) ? dirx_q : diry_q)
                 + $signed(prod_q[FRAC_VEC+RAY_W-1:FRAC_VEC]);
  assign ray_abs = ray[RAY_W-1] ? ABS_W'(-ray) : ABS_W'(ray);

  // ---------------------------------------------------------------------------
  // Walk and shading state
  // ---------------------------------------------------------------------------
  logic                sx_neg_q, sy_neg_q, side_q;
  logic [1:0]          kind_q;
  logic [PROD_W-1:0]   p1_q;
  logic [6:0]          lh_q;
  logic                lt_near_q, lt_mid_q, lt_far_q;
  logic [ROW_W-1:0]    row_q;
  logic                out_of_map;
  logic                shade_lt;

  assign out_of_map = (mx_q[CELL_W-1:MAP_AW] != '0) || (my_q[CELL_W-1:MAP_AW] != '0);
  assign shade_lt   = {16'd0, num_q, 4'd0} < $unsigned(prod_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        col_q  <= in_i.column;
        px_q   <= in_i.pos_x;
        py_q   <= in_i.pos_y;
        dirx_q <= in_i.dir_x;
        diry_q <= in_i.dir_y;
        plx_q  <= in_i.plane_x;
        ply_q  <= in_i.plane_y;
        cam_q  <= $signed(cam_base - VEC_W'(16384));
      end
      ST_MULY: begin
        ax_q     <= ray_abs;
        sx_neg_q <= ray[RAY_W-1];
        tx_q     <= ray[RAY_W-1] ? DIST_W'(px_q[FRAC_POS-1:0])
                               : DIST_W'(CELL_STEP) - DIST_W'(px_q[FRAC_POS-1:0]);
        mx_q     <= CELL_W'(px_q[POS_W-1:FRAC_POS]);
      end
      ST_INIT: begin
        ay_q     <= ray_abs;
        sy_neg_q <= ray[RAY_W-1];
        ty_q     <= ray[RAY_W-1] ? DIST_W'(py_q[FRAC_POS-1:0])
                               : DIST_W'(CELL_STEP) - DIST_W'(py_q[FRAC_POS-1:0]);
        my_q     <= CELL_W'(py_q[POS_W-1:FRAC_POS]);
        num_q    <= '0;
        den_q    <= '0;
        side_q   <= 1'b1;
      end
      ST_S2: begin
        p1_q <= $unsigned(prod_q);
      end
      ST_S3: begin
        // advance along whichever boundary comes first; ties go to the y axis
        if (p1_q < $unsigned(prod_q)) begin
          num_q  <= tx_q;
          den_q  <= ax_q;
          tx_q   <= tx_q + DIST_W'(CELL_STEP);
          mx_q   <= sx_neg_q ? mx_q - 1'b1 : mx_q + 1'b1;
          side_q <= 1'b0;
        end else begin
          num_q  <= ty_q;
          den_q  <= ay_q;
          ty_q   <= ty_q + DIST_W'(CELL_STEP);
          my_q   <= sy_neg_q ? my_q - 1'b1 : my_q + 1'b1;
          side_q <= 1'b1;
        end
      end
      ST_RD: begin
        // leaving the map counts as a plain wall
        if (out_of_map) begin
          kind_q <= KIND_WALL;
        end
      end
      ST_CHK: begin
        kind_q <= rd_q;
      end
      ST_LHD: begin
        if (num_q == '0) begin
          lh_q <= 7'(LH_MAX);
        end
      end
      ST_LHW: begin
        lh_q <= (div_rsp.quot >= DVD_W'(LH_MAX)) ? 7'(LH_MAX) : div_rsp.quot[6:0];
      end
      ST_SH1: lt_near_q <= shade_lt;
      ST_SH2: lt_mid_q  <= shade_lt;
      ST_SH3: lt_far_q  <= shade_lt;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Span and glyph selection
  // ---------------------------------------------------------------------------
  logic [5:0]       half;
  logic [ROW_W-1:0] span_start, span_end;
  logic [6:0]       end_sum;
  logic [2:0]       wall_glyph, row_glyph;

  assign half       = lh_q[6:1];
  assign span_start = (half > 6'(HALF_ROWS)) ? '0 : ROW_W'(6'(HALF_ROWS) - half);
  assign end_sum    = 7'(half) + 7'(HALF_ROWS);
  assign span_end   = (end_sum > 7'(SCREEN_ROWS - 1)) ? ROW_W'(SCREEN_ROWS - 1)
                                                      : ROW_W'(end_sum);

  always_comb begin
    if (kind_q == KIND_EXIT) begin
      wall_glyph = GLYPH_EXIT;
    end else if (!side_q) begin
      wall_glyph = lt_near_q ? GLYPH_HASH :
                   lt_mid_q  ? GLYPH_X    :
                   lt_far_q  ? GLYPH_PLUS : GLYPH_COLON;
    end else begin
      wall_glyph = lt_near_q ? GLYPH_X    :
                   lt_mid_q  ? GLYPH_PLUS : GLYPH_COLON;
    end
    if (row_q < span_start) begin
      row_glyph = GLYPH_SPACE;
    end else if (row_q < span_end) begin
      row_glyph = wall_glyph;
    end else begin
      row_glyph = floor_glyph(row_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: while emitting, load a row whenever the slot is free or being taken
  // ---------------------------------------------------------------------------
  logic             ov_q;
  logic             out_load;
  logic [COL_W-1:0] oc_q;
  logic [ROW_W-1:0] orow_q;
  logic [2:0]       og_q;
  logic             olast_q;

  assign out_load = (state_q == ST_EMIT) && (!ov_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      row_q <= '0;
    end else begin
      if (out_load) begin
        ov_q  <= 1'b1;
        row_q <= (row_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_q + 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oc_q    <= col_q;
      orow_q  <= row_q;
      og_q    <= row_glyph;
      olast_q <= (row_q == ROW_W'(SCREEN_ROWS - 1));
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_column = oc_q;
  assign out_o.row        = orow_q;
  assign out_o.glyph      = og_q;
  assign out_o.last       = olast_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == MAP_IDX_W'(MAP_CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_acc && (in_i.cmd == CMD_CAST)) state_d = ST_MULX;
      ST_MULX: state_d = ST_MULY;
      ST_MULY: state_d = ST_INIT;
      ST_INIT: state_d = ST_S1;
      ST_S1:   state_d = ST_S2;
      ST_S2:   state_d = ST_S3;
      ST_S3:   state_d = ST_RD;
      ST_RD:   state_d = out_of_map ? ST_LHM : ST_CHK;
      ST_CHK:  state_d = (rd_q != KIND_EMPTY) ? ST_LHM : ST_S2;
      ST_LHM:  state_d = ST_LHD;
      ST_LHD:  state_d = (num_q == '0) ? ST_SH0 : ST_LHW;
      ST_LHW:  if (div_rsp.done) state_d = ST_SH0;
      ST_SH0:  state_d = ST_SH1;
      ST_SH1:  state_d = ST_SH2;
      ST_SH2:  state_d = ST_SH3;
      ST_SH3:  state_d = ST_EMIT;
      ST_EMIT: if (out_load && (row_q == ROW_W'(SCREEN_ROWS - 1))) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
